// ===== src/rgbapk_pkg.sv =====
// Shared types and constants for the RGBA to masked pixel packer.
`default_nettype none

package rgbapk_pkg;

   localparam int CHAN_BITS = 8;
   localparam int WORD_BITS = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int BPP_BITS = 3;

   typedef logic [CHAN_BITS-1:0] chan_type;
   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [BPP_BITS-1:0] bpp_type;

   localparam csr_index_type REG_RED_MASK = 3'd0;
   localparam csr_index_type REG_GREEN_MASK = 3'd1;
   localparam csr_index_type REG_BLUE_MASK = 3'd2;
   localparam csr_index_type REG_ALPHA_MASK = 3'd3;
   localparam csr_index_type REG_BYTES_PER_PIXEL = 3'd4;

   localparam word_type RED_MASK_RESET = 32'h00FF_0000;
   localparam word_type GREEN_MASK_RESET = 32'h0000_FF00;
   localparam word_type BLUE_MASK_RESET = 32'h0000_00FF;
   localparam word_type ALPHA_MASK_RESET = 32'hFF00_0000;
   localparam bpp_type BYTES_PER_PIXEL_RESET = 3'd4;

   // Bits kept in the packed word for a given byte count; above four keeps all.
   function automatic word_type keep_mask(bpp_type nbytes);
      word_type keep;
      case (nbytes)
         3'd0: keep = '0;
         3'd1: keep = 32'h0000_00FF;
         3'd2: keep = 32'h0000_FFFF;
         3'd3: keep = 32'h00FF_FFFF;
         default: keep = '1;
      endcase
      return keep;
   endfunction

endpackage

`default_nettype wire

// ===== src/rgbapk_if.sv =====
// Valid/ready channel interfaces for source pixels and packed pixels.
`default_nettype none

interface rgbapk_req_if
   import rgbapk_pkg::*;
();
   logic valid;
   logic ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   chan_type alpha;

   modport source (output valid, output red, output green, output blue, output alpha,
                   input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 output ready);
endinterface

interface rgbapk_rsp_if
   import rgbapk_pkg::*;
();
   logic valid;
   logic ready;
   word_type packed_pixel;

   modport source (output valid, output packed_pixel, input ready);
   modport sink (input valid, input packed_pixel, output ready);
endinterface

`default_nettype wire

// ===== src/rgbapk_place.sv =====
// Places one 8-bit channel into the lowest run of ones of its mask.
`default_nettype none

module rgbapk_place
   import rgbapk_pkg::*;
(
   input  word_type mask,
   input  chan_type value,
   output word_type placed
);

   word_type low;
   word_type sum;
   word_type run;
   logic [WORD_BITS:0] end_bit;
   logic [2:0] end_pos;
   chan_type rot;

   // Isolate the lowest run: adding the lowest set bit ripples through the run.
   assign low = mask & (~mask + 32'd1);
   assign sum = mask + low;
   assign run = mask & ~sum;
   assign end_bit = {run, 1'b0} & ~{1'b0, run};

   // Only the end position mod 8 matters: field bit j takes value[(j - end) mod 8].
   always_comb begin
      end_pos = '0;
      for (int k = 0; k <= WORD_BITS; k++) begin
         if (end_bit[k]) begin
            end_pos = end_pos | 3'(k);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < CHAN_BITS; i++) begin
         rot[i] = value[3'(i) - end_pos];
      end
   end

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         placed[j] = run[j] & rot[3'(j)];
      end
   end

endmodule

`default_nettype wire

// ===== src/rgba_to_masked_pixel_packer.sv =====
// Top level: RGBA pixel in, mask-packed pixel word out.
//
//   channel | direction | payload                      | word accepted when
//   req     | in        | red, green, blue, alpha      | req.valid && req.ready
//   rsp     | out       | packed_pixel                 | rsp.valid && rsp.ready
//   csr     | in        | csr_index, csr_wdata         | csr_we
//
// One pixel per clock while rsp does not stall; an accepted word is loaded into the
// input register, then into the result register, and shows on rsp from there.
// Mask decode, rotate, OR and byte-count keep run as a single combinational pass
// between those two registers.
// Reset clears both stage valids and loads the default masks and byte count.
// A stall on rsp holds the result register and backs up into the input
// register; req.ready drops only when both are full.
`default_nettype none

module rgba_to_masked_pixel_packer
   import rgbapk_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rgbapk_req_if.sink req_chan,
   rgbapk_rsp_if.source rsp_chan,
   input  wire logic csr_we,
   input  wire csr_index_type csr_index,
   input  wire word_type csr_wdata
);

   word_type red_mask_ff;
   word_type green_mask_ff;
   word_type blue_mask_ff;
   word_type alpha_mask_ff;
   bpp_type bpp_ff;

   logic in_valid_ff;
   chan_type red_ff;
   chan_type green_ff;
   chan_type blue_ff;
   chan_type alpha_ff;

   logic out_valid_ff;
   word_type pixel_ff;
   word_type pixel_in;

   logic out_advance;
   logic in_advance;

   word_type red_placed;
   word_type green_placed;
   word_type blue_placed;
   word_type alpha_placed;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_mask_ff <= RED_MASK_RESET;
         green_mask_ff <= GREEN_MASK_RESET;
         blue_mask_ff <= BLUE_MASK_RESET;
         alpha_mask_ff <= ALPHA_MASK_RESET;
         bpp_ff <= BYTES_PER_PIXEL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_RED_MASK: red_mask_ff <= csr_wdata;
            REG_GREEN_MASK: green_mask_ff <= csr_wdata;
            REG_BLUE_MASK: blue_mask_ff <= csr_wdata;
            REG_ALPHA_MASK: alpha_mask_ff <= csr_wdata;
            REG_BYTES_PER_PIXEL: bpp_ff <= csr_wdata[BPP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Advance a stage when the one after it can take its word.
   assign out_advance = !out_valid_ff || rsp_chan.ready;
   assign in_advance = !in_valid_ff || out_advance;
   assign req_chan.ready = in_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_advance) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         red_ff <= req_chan.red;
         green_ff <= req_chan.green;
         blue_ff <= req_chan.blue;
         alpha_ff <= req_chan.alpha;
      end
      if (out_advance) begin
         pixel_ff <= pixel_in;
      end
   end

   rgbapk_place u_red (.mask(red_mask_ff), .value(red_ff), .placed(red_placed));
   rgbapk_place u_green (.mask(green_mask_ff), .value(green_ff), .placed(green_placed));
   rgbapk_place u_blue (.mask(blue_mask_ff), .value(blue_ff), .placed(blue_placed));
   rgbapk_place u_alpha (.mask(alpha_mask_ff), .value(alpha_ff), .placed(alpha_placed));

   assign pixel_in = (red_placed | green_placed | blue_placed | alpha_placed)
                     & keep_mask(bpp_ff);

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.packed_pixel = pixel_ff;

endmodule

`default_nettype wire
